@@ rtl/bbtr_pkg.sv @@
`default_nettype none

package bbtr_pkg;

   localparam int BBTR_MAX_BLOCKS  = 1024;
   localparam int BBTR_QUEUE_DEPTH = 2;

   typedef enum logic [1:0] {
      KIND_LOAD   = 2'd0,
      KIND_QUERY  = 2'd1,
      KIND_CLEAR  = 2'd2,
      KIND_UNUSED = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      OP_LOAD,
      OP_QUERY,
      OP_CLEAR,
      OP_NOP
   } op_type;

   typedef enum logic [1:0] {
      STATUS_OK         = 2'd0,
      STATUS_FULL       = 2'd1,
      STATUS_NOT_LOADED = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_INFO,
      ST_CHECK,
      ST_PACK
   } state_type;

   typedef struct packed {
      op_type      op;
      logic [47:0] start;
      logic [31:0] length;
      logic [3:0]  size;
      logic [47:0] target;
      logic        known;
      logic        cond;
      logic [9:0]  idx;
   } cmd_type;

   typedef struct packed {
      logic [47:0] start;
      logic [31:0] length;
      logic [3:0]  size;
      logic        known;
      logic [47:0] target;
      logic        cond;
   } entry_type;

   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } queue_head_type;

endpackage

`default_nettype wire

@@ rtl/bbtr_ram.sv @@
`default_nettype none

module bbtr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ rtl/bbtr_front.sv @@
`default_nettype none

module bbtr_front
   import bbtr_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_kind,
   input  wire logic [47:0] req_start_offset,
   input  wire logic [31:0] req_block_length,
   input  wire logic [3:0]  req_last_insn_size,
   input  wire logic [47:0] req_target_offset,
   input  wire logic        req_target_known,
   input  wire logic        req_is_conditional,
   input  wire logic [9:0]  req_block_index,
   output queue_head_type   head,
   input  wire logic        pop
);

   localparam int QAW = (BBTR_QUEUE_DEPTH > 1) ? $clog2(BBTR_QUEUE_DEPTH) : 1;
   localparam int QFW = $clog2(BBTR_QUEUE_DEPTH + 1);

   cmd_type        entry_ff [BBTR_QUEUE_DEPTH];
   logic [QAW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QAW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QFW-1:0] fill_ff, fill_in;
   cmd_type        cmd;
   logic           push;
   logic           do_pop;

   always_comb begin
      cmd.start  = req_start_offset;
      cmd.length = req_block_length;
      cmd.size   = req_last_insn_size;
      cmd.target = req_target_offset;
      cmd.known  = req_target_known;
      cmd.cond   = req_is_conditional;
      cmd.idx    = req_block_index;
      unique case (kind_type'(req_kind))
         KIND_LOAD:   cmd.op = OP_LOAD;
         KIND_QUERY:  cmd.op = OP_QUERY;
         KIND_CLEAR:  cmd.op = OP_CLEAR;
         KIND_UNUSED: cmd.op = OP_NOP;
         default:     cmd.op = OP_NOP;
      endcase
   end

   assign req_stall = (fill_ff == QFW'(BBTR_QUEUE_DEPTH));
   assign push      = req_valid && !req_stall;
   assign do_pop    = pop && (fill_ff != '0);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QAW'(BBTR_QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QAW'(BBTR_QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (!push && do_pop) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= cmd;
      end
   end

   assign head.valid = (fill_ff != '0);
   assign head.cmd   = entry_ff[rd_ptr_ff];

endmodule

`default_nettype wire

@@ rtl/bbtr_back.sv @@
`default_nettype none

module bbtr_back
   import bbtr_pkg::*;
#(
   parameter int MAX_BLOCKS = BBTR_MAX_BLOCKS
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  queue_head_type   head,
   output logic             pop,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [1:0]       rsp_status,
   output logic [63:0]      rsp_packed_index_word,
   output logic [63:0]      rsp_packed_address_word,
   output logic             rsp_target_found
);

   localparam int IW = $clog2(MAX_BLOCKS);
   localparam int CW = $clog2(MAX_BLOCKS + 1);
   localparam int XW = (CW > 10) ? CW : 10;
   localparam int EW = $bits(entry_type);

   state_type   state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [31:0] slide_ff, slide_in;
   logic [CW-1:0] lo_ff, lo_in;
   logic [CW-1:0] hip1_ff, hip1_in;
   logic [IW-1:0] mid_ff, mid_in;
   logic [47:0] target_ff, target_in;
   logic        cond_ff, cond_in;
   logic [9:0]  idx_ff, idx_in;
   logic [31:0] ntrel_ff, ntrel_in;
   logic        found_ff, found_in;
   logic [IW-1:0] fidx_ff, fidx_in;
   logic [30:0] trel_ff, trel_in;
   logic        rsp_valid_ff, rsp_valid_in;
   status_type  rsp_status_ff, rsp_status_in;
   logic [63:0] rsp_piw_ff, rsp_piw_in;
   logic [63:0] rsp_paw_ff, rsp_paw_in;
   logic        rsp_found_ff, rsp_found_in;

   logic          ram_wr_en;
   logic [IW-1:0] ram_wr_addr;
   logic          ram_rd_en;
   logic [IW-1:0] ram_rd_addr;
   logic [EW-1:0] ram_rd_data;
   entry_type     wr_entry;
   entry_type     rd_entry;

   logic          slot_free;
   logic          full;
   logic          idx_bad;
   logic          hit;
   logic [48:0]   probe_end;
   logic [CW-1:0] nlo, nhi;
   logic          cont;
   logic [IW-1:0] first_mid, next_mid;
   logic [30:0]   nt_idx;

   function automatic logic [IW-1:0] mid_of(input logic [CW-1:0] lo, input logic [CW-1:0] hi);
      logic [CW:0] sum;
      sum = {1'b0, lo} + {1'b0, hi} - 1'b1;
      return IW'(sum >> 1);
   endfunction

   bbtr_ram #(
      .WIDTH(EW),
      .DEPTH(MAX_BLOCKS)
   ) u_ram (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data(wr_entry),
      .rd_en  (ram_rd_en),
      .rd_addr(ram_rd_addr),
      .rd_data(ram_rd_data)
   );

   assign rd_entry = entry_type'(ram_rd_data);

   always_comb begin
      wr_entry.start  = head.cmd.start;
      wr_entry.length = head.cmd.length;
      wr_entry.size   = head.cmd.size;
      wr_entry.known  = head.cmd.known;
      wr_entry.target = head.cmd.target;
      wr_entry.cond   = head.cmd.cond;
   end

   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign pop       = (state_ff == ST_IDLE) && head.valid && slot_free;
   assign full      = (count_ff == CW'(MAX_BLOCKS));
   assign idx_bad   = XW'(head.cmd.idx) >= XW'(count_ff);

   assign probe_end = {1'b0, rd_entry.start} + {17'b0, rd_entry.length};
   assign hit       = (rd_entry.start <= target_ff) && ({1'b0, target_ff} <= probe_end);
   assign nlo       = (target_ff < rd_entry.start) ? lo_ff : CW'(mid_ff) + 1'b1;
   assign nhi       = (target_ff < rd_entry.start) ? CW'(mid_ff) : hip1_ff;
   assign cont      = nlo < nhi;
   assign first_mid = mid_of('0, count_ff);
   assign next_mid  = mid_of(nlo, nhi);
   assign nt_idx    = 31'(idx_ff) + 31'd1;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (pop && head.cmd.op == OP_QUERY && !idx_bad) begin
               state_in = ST_INFO;
            end
         end
         ST_INFO:  state_in = rd_entry.known ? ST_CHECK : ST_PACK;
         ST_CHECK: state_in = (hit || !cont) ? ST_PACK : ST_CHECK;
         ST_PACK:  state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      ram_wr_en   = 1'b0;
      ram_wr_addr = IW'(count_ff);
      ram_rd_en   = 1'b0;
      ram_rd_addr = IW'(head.cmd.idx);
      unique case (state_ff)
         ST_IDLE: begin
            if (pop && head.cmd.op == OP_LOAD && !full) begin
               ram_wr_en = 1'b1;
            end
            if (pop && head.cmd.op == OP_QUERY && !idx_bad) begin
               ram_rd_en = 1'b1;
            end
         end
         ST_INFO: begin
            ram_rd_en   = rd_entry.known;
            ram_rd_addr = first_mid;
         end
         ST_CHECK: begin
            ram_rd_en   = !hit && cont;
            ram_rd_addr = next_mid;
         end
         ST_PACK: begin
            ram_rd_en = 1'b0;
         end
         default: begin
            ram_rd_en = 1'b0;
         end
      endcase
   end

   always_comb begin
      count_in      = count_ff;
      slide_in      = slide_ff;
      lo_in         = lo_ff;
      hip1_in       = hip1_ff;
      mid_in        = mid_ff;
      target_in     = target_ff;
      cond_in       = cond_ff;
      idx_in        = idx_ff;
      ntrel_in      = ntrel_ff;
      found_in      = found_ff;
      fidx_in       = fidx_ff;
      trel_in       = trel_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_piw_in    = rsp_piw_ff;
      rsp_paw_in    = rsp_paw_ff;
      rsp_found_in  = rsp_found_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (pop) begin
               rsp_status_in = STATUS_OK;
               rsp_piw_in    = '0;
               rsp_paw_in    = '0;
               rsp_found_in  = 1'b0;
               rsp_valid_in  = 1'b1;
               idx_in        = head.cmd.idx;
               unique case (head.cmd.op)
                  OP_LOAD: begin
                     if (full) begin
                        rsp_status_in = STATUS_FULL;
                     end else begin
                        count_in = count_ff + 1'b1;
                        if (count_ff == '0) begin
                           slide_in = head.cmd.start[31:0];
                        end
                     end
                  end
                  OP_QUERY: begin
                     if (idx_bad) begin
                        rsp_status_in = STATUS_NOT_LOADED;
                     end else begin
                        rsp_valid_in = 1'b0;
                     end
                  end
                  OP_CLEAR: count_in = '0;
                  OP_NOP:   count_in = count_ff;
                  default:  count_in = count_ff;
               endcase
            end
         end
         ST_INFO: begin
            cond_in   = rd_entry.cond;
            ntrel_in  = rd_entry.start[31:0] + rd_entry.length + 32'(rd_entry.size) - slide_ff;
            target_in = rd_entry.target;
            found_in  = 1'b0;
            lo_in     = '0;
            hip1_in   = count_ff;
            mid_in    = first_mid;
         end
         ST_CHECK: begin
            if (hit) begin
               found_in = 1'b1;
               fidx_in  = mid_ff;
               trel_in  = rd_entry.start[30:0] - slide_ff[30:0];
            end else begin
               lo_in   = nlo;
               hip1_in = nhi;
               mid_in  = next_mid;
            end
         end
         ST_PACK: begin
            rsp_valid_in  = 1'b1;
            rsp_status_in = STATUS_OK;
            rsp_found_in  = found_ff;
            rsp_piw_in    = {cond_ff ? nt_idx : 31'd0, 1'b0,
                             found_ff ? 31'(fidx_ff) : 31'h7FFF_FFFF, cond_ff};
            rsp_paw_in    = {cond_ff ? ntrel_ff : 32'd0, 1'b0,
                             found_ff ? trel_ff : 31'h7FFF_FFFF};
         end
         default: begin
            rsp_valid_in = rsp_valid_ff && rsp_stall;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      slide_ff      <= slide_in;
      lo_ff         <= lo_in;
      hip1_ff       <= hip1_in;
      mid_ff        <= mid_in;
      target_ff     <= target_in;
      cond_ff       <= cond_in;
      idx_ff        <= idx_in;
      ntrel_ff      <= ntrel_in;
      found_ff      <= found_in;
      fidx_ff       <= fidx_in;
      trel_ff       <= trel_in;
      rsp_status_ff <= rsp_status_in;
      rsp_piw_ff    <= rsp_piw_in;
      rsp_paw_ff    <= rsp_paw_in;
      rsp_found_ff  <= rsp_found_in;
   end

   assign rsp_valid               = rsp_valid_ff;
   assign rsp_status              = rsp_status_ff;
   assign rsp_packed_index_word   = rsp_piw_ff;
   assign rsp_packed_address_word = rsp_paw_ff;
   assign rsp_target_found        = rsp_found_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_BLOCKS))
      else $error("loaded block count exceeds capacity");

   a_search_window: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CHECK |-> (lo_ff < hip1_ff) && (hip1_ff <= count_ff)
                               && (CW'(mid_ff) >= lo_ff) && (CW'(mid_ff) < hip1_ff))
      else $error("search probe outside its window");

   a_busy_no_rsp: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_IDLE |-> !rsp_valid_ff)
      else $error("result pending while a query is in progress");

   a_write_idle: assert property (@(posedge clock) disable iff (reset)
      ram_wr_en |-> state_ff == ST_IDLE && pop && !full)
      else $error("table write outside a load");

   a_clear_count: assert property (@(posedge clock) disable iff (reset)
      pop && head.cmd.op == OP_CLEAR |=> count_ff == '0)
      else $error("clear did not empty the table");

endmodule

`default_nettype wire

@@ rtl/branch_block_table_resolver.sv @@
`default_nettype none

// Branch block table resolver. Items enter a two-deep queue and are carried out one at a
// time against a block table of MAX_BLOCKS entries with one write port and one registered
// read port. A load, a clear, an unused kind or a query of an unloaded index is answered
// from the idle state of the back end. A query of a loaded block passes the info state, the
// check state once per search probe if its target is known, and the pack state; each probe
// is one read of the table, with at most ceil(log2(n + 1)) probes for n loaded blocks. The
// table needs no clearing pass after reset; loads beyond capacity get a full status.
module branch_block_table_resolver
   import bbtr_pkg::*;
#(
   parameter int MAX_BLOCKS = BBTR_MAX_BLOCKS
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_kind,
   input  wire logic [47:0] req_start_offset,
   input  wire logic [31:0] req_block_length,
   input  wire logic [3:0]  req_last_insn_size,
   input  wire logic [47:0] req_target_offset,
   input  wire logic        req_target_known,
   input  wire logic        req_is_conditional,
   input  wire logic [9:0]  req_block_index,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [1:0]       rsp_status,
   output logic [63:0]      rsp_packed_index_word,
   output logic [63:0]      rsp_packed_address_word,
   output logic             rsp_target_found
);

   queue_head_type head;
   logic           pop;

   bbtr_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_kind          (req_kind),
      .req_start_offset  (req_start_offset),
      .req_block_length  (req_block_length),
      .req_last_insn_size(req_last_insn_size),
      .req_target_offset (req_target_offset),
      .req_target_known  (req_target_known),
      .req_is_conditional(req_is_conditional),
      .req_block_index   (req_block_index),
      .head              (head),
      .pop               (pop)
   );

   bbtr_back #(
      .MAX_BLOCKS(MAX_BLOCKS)
   ) u_back (
      .clock                  (clock),
      .reset                  (reset),
      .head                   (head),
      .pop                    (pop),
      .rsp_valid              (rsp_valid),
      .rsp_stall              (rsp_stall),
      .rsp_status             (rsp_status),
      .rsp_packed_index_word  (rsp_packed_index_word),
      .rsp_packed_address_word(rsp_packed_address_word),
      .rsp_target_found       (rsp_target_found)
   );

endmodule

`default_nettype wire
